// File: rtl/core/blr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Braille line rasterizer package
// Request and response types, request kinds, register indexes and the dot
// bit table shared by the rasterizer.
// ----------------------------------------------------------------------------
package blr_pkg;

  localparam logic [1:0] ReqClear = 2'd0;
  localparam logic [1:0] ReqDraw  = 2'd1;
  localparam logic [1:0] ReqRead  = 2'd2;

  localparam logic CfgPlotColumns = 1'b0;
  localparam logic CfgPlotRows    = 1'b1;

  localparam logic [7:0] PlotColumnsReset = 8'd128;
  localparam logic [6:0] PlotRowsReset    = 7'd64;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] x_start;
    logic [7:0] y_start;
    logic [7:0] x_end;
    logic [7:0] y_end;
    logic [6:0] read_column;
    logic [5:0] read_row;
  } blr_req_t;

  typedef struct packed {
    logic [7:0] cell_bits;
    logic [1:0] done_kind;
  } blr_rsp_t;

  // Braille dot bit for a subpixel row (y mod 4) and column (x mod 2).
  function automatic logic [7:0] dot_bit(input logic [1:0] sub_row, input logic sub_col);
    logic [7:0] bits;
    case ({sub_row, sub_col})
      3'b000:  bits = 8'h01;
      3'b001:  bits = 8'h08;
      3'b010:  bits = 8'h02;
      3'b011:  bits = 8'h10;
      3'b100:  bits = 8'h04;
      3'b101:  bits = 8'h20;
      3'b110:  bits = 8'h40;
      default: bits = 8'h80;
    endcase
    return bits;
  endfunction

endpackage

// File: rtl/core/braille_line_rasterizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Braille line rasterizer
// A store of Braille cells with line drawing, clearing and single-cell reads.
// ----------------------------------------------------------------------------
// A transaction is accepted when start is high and busy is low; req_i holds
// the request kind, the line end points and the cell to read. Each clear,
// draw or read request returns one response on rsp_o, marked by done_o for
// exactly one cycle, in the cycle after the request finishes. The receiver
// cannot stall; responses are never held back. An unused request kind is
// accepted and returns nothing.
// A draw walks one dot per cycle through a single Bresenham step unit and a
// read-modify-write on the cell memory, which forwards the previous write
// so that dots landing in the same cell merge, and ends with a drain state.
// A clear sweeps the memory one cell per cycle. At reset the same clearing
// pass runs with busy high and no response; configuration writes through
// cfg_we_i are taken at any time and should be made only while the block is
// idle.
// ----------------------------------------------------------------------------
module braille_line_rasterizer
  import blr_pkg::*;
#(
  parameter int unsigned MAX_COLUMNS = 128,
  parameter int unsigned MAX_ROWS    = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  blr_req_t req_i,
  output logic     done_o,
  output blr_rsp_t rsp_o,
  input  logic     cfg_we_i,
  input  logic     cfg_idx_i,
  input  logic [7:0] cfg_data_i
);

  localparam int unsigned Depth = MAX_COLUMNS * MAX_ROWS;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam logic [10:0] MaxCols = 11'(MAX_COLUMNS);
  localparam logic [10:0] MaxRows = 11'(MAX_ROWS);
  localparam logic [AW-1:0] LastAddr = AW'(Depth - 1);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StClear = 3'd1;
  localparam logic [2:0] StDraw  = 3'd2;
  localparam logic [2:0] StDrain = 3'd3;
  localparam logic [2:0] StRead  = 3'd4;

  logic [2:0] state_q, state_d;
  logic [7:0] plot_columns_q;
  logic [6:0] plot_rows_q;
  logic [AW-1:0] clr_addr_q, clr_addr_d;
  logic report_q, report_d;
  logic done_q, done_d;
  blr_rsp_t rsp_q, rsp_d;

  logic [7:0] x_q, x_d, y_q, y_d, xe_q, xe_d, ye_q, ye_d;
  logic signed [11:0] dx_q, dx_d, dy_q, dy_d, err_q, err_d;
  logic sx_neg_q, sx_neg_d, sy_neg_q, sy_neg_d;

  logic s_valid_q, s_valid_d;
  logic [AW-1:0] s_addr_q, s_addr_d;
  logic [7:0] s_bit_q, s_bit_d;
  logic last_valid_q;
  logic [AW-1:0] last_addr_q;
  logic [7:0] last_wdata_q;
  logic rd_ok_q, rd_ok_d;

  logic [7:0] cell_mem [Depth];
  logic [7:0] rdata_q;
  logic mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0] mem_wdata, merged;

  logic [10:0] cols_eff, rows_eff;
  logic dot_in_area, req_in_area;
  logic [AW-1:0] dot_addr, req_addr;
  logic signed [11:0] twice;
  logic step_x, step_y;
  logic [7:0] dx_abs, dy_abs;

  function automatic logic [AW-1:0] cell_addr(input logic [5:0] row, input logic [6:0] col);
    return AW'(32'(row) * 32'(MAX_COLUMNS) + 32'(col));
  endfunction

  assign cols_eff = (11'(plot_columns_q) > MaxCols) ? MaxCols : 11'(plot_columns_q);
  assign rows_eff = (11'(plot_rows_q) > MaxRows) ? MaxRows : 11'(plot_rows_q);

  assign dot_in_area = (11'(x_q[7:1]) < cols_eff) && (11'(y_q[7:2]) < rows_eff);
  assign dot_addr    = dot_in_area ? cell_addr(y_q[7:2], x_q[7:1]) : '0;
  assign req_in_area = (11'(req_i.read_column) < cols_eff) && (11'(req_i.read_row) < rows_eff);
  assign req_addr    = req_in_area ? cell_addr(req_i.read_row, req_i.read_column) : '0;

  assign twice  = {err_q[10:0], 1'b0};
  assign step_x = (twice >= dy_q);
  assign step_y = (twice <= dx_q);
  assign dx_abs = (req_i.x_end > req_i.x_start) ? req_i.x_end - req_i.x_start
                                                : req_i.x_start - req_i.x_end;
  assign dy_abs = (req_i.y_end > req_i.y_start) ? req_i.y_end - req_i.y_start
                                                : req_i.y_start - req_i.y_end;

  assign merged = ((last_valid_q && (last_addr_q == s_addr_q)) ? last_wdata_q : rdata_q)
                  | s_bit_q;

  always_comb begin
    if (state_q == StClear) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_q;
      mem_wdata = 8'h00;
    end else begin
      mem_we    = s_valid_q;
      mem_waddr = s_addr_q;
      mem_wdata = merged;
    end
    mem_raddr = (state_q == StIdle) ? req_addr : dot_addr;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      cell_mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= cell_mem[mem_raddr];
  end

  always_comb begin
    state_d    = state_q;
    clr_addr_d = clr_addr_q;
    report_d   = report_q;
    done_d     = 1'b0;
    rsp_d      = rsp_q;
    x_d        = x_q;
    y_d        = y_q;
    xe_d       = xe_q;
    ye_d       = ye_q;
    dx_d       = dx_q;
    dy_d       = dy_q;
    err_d      = err_q;
    sx_neg_d   = sx_neg_q;
    sy_neg_d   = sy_neg_q;
    s_valid_d  = 1'b0;
    s_addr_d   = dot_addr;
    s_bit_d    = dot_bit(y_q[1:0], x_q[0]);
    rd_ok_d    = rd_ok_q;
    unique case (state_q)
      StIdle: begin
        if (start) begin
          unique case (req_i.req_type)
            ReqClear: begin
              clr_addr_d = '0;
              report_d   = 1'b1;
              state_d    = StClear;
            end
            ReqDraw: begin
              x_d      = req_i.x_start;
              y_d      = req_i.y_start;
              xe_d     = req_i.x_end;
              ye_d     = req_i.y_end;
              dx_d     = signed'({4'b0000, dx_abs});
              dy_d     = -signed'({4'b0000, dy_abs});
              err_d    = signed'({4'b0000, dx_abs}) - signed'({4'b0000, dy_abs});
              sx_neg_d = !(req_i.x_start < req_i.x_end);
              sy_neg_d = !(req_i.y_start < req_i.y_end);
              state_d  = StDraw;
            end
            ReqRead: begin
              rd_ok_d = req_in_area;
              state_d = StRead;
            end
            default: begin
            end
          endcase
        end
      end
      StClear: begin
        clr_addr_d = clr_addr_q + AW'(1);
        if (clr_addr_q == LastAddr) begin
          state_d  = StIdle;
          done_d   = report_q;
          rsp_d    = '{cell_bits: 8'h00, done_kind: ReqClear};
          report_d = 1'b0;
        end
      end
      StDraw: begin
        s_valid_d = dot_in_area;
        if ((x_q == xe_q) && (y_q == ye_q)) begin
          state_d = StDrain;
        end else begin
          if (step_x) begin
            x_d = sx_neg_q ? x_q - 8'd1 : x_q + 8'd1;
          end
          if (step_y) begin
            y_d = sy_neg_q ? y_q - 8'd1 : y_q + 8'd1;
          end
          err_d = err_q + (step_x ? dy_q : 12'sd0) + (step_y ? dx_q : 12'sd0);
        end
      end
      StDrain: begin
        state_d = StIdle;
        done_d  = 1'b1;
        rsp_d   = '{cell_bits: 8'h00, done_kind: ReqDraw};
      end
      StRead: begin
        state_d = StIdle;
        done_d  = 1'b1;
        rsp_d   = '{cell_bits: rd_ok_q ? rdata_q : 8'h00, done_kind: ReqRead};
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StClear;
      clr_addr_q     <= '0;
      report_q       <= 1'b0;
      done_q         <= 1'b0;
      s_valid_q      <= 1'b0;
      last_valid_q   <= 1'b0;
      plot_columns_q <= PlotColumnsReset;
      plot_rows_q    <= PlotRowsReset;
    end else begin
      state_q      <= state_d;
      clr_addr_q   <= clr_addr_d;
      report_q     <= report_d;
      done_q       <= done_d;
      s_valid_q    <= s_valid_d;
      last_valid_q <= s_valid_q;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgPlotColumns: plot_columns_q <= cfg_data_i;
          CfgPlotRows:    plot_rows_q    <= cfg_data_i[6:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q        <= rsp_d;
    x_q          <= x_d;
    y_q          <= y_d;
    xe_q         <= xe_d;
    ye_q         <= ye_d;
    dx_q         <= dx_d;
    dy_q         <= dy_d;
    err_q        <= err_d;
    sx_neg_q     <= sx_neg_d;
    sy_neg_q     <= sy_neg_d;
    s_addr_q     <= s_addr_d;
    s_bit_q      <= s_bit_d;
    last_addr_q  <= s_addr_q;
    last_wdata_q <= merged;
    rd_ok_q      <= rd_ok_d;
  end

  assign busy   = (state_q != StIdle);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule
